// ----- rtl/core/nns_pkg.sv -----
`timescale 1ns / 1ps

package nns_pkg;

    localparam int COORD_BITS = 10;
    localparam int INDEX_W    = 12;
    localparam int DIST_W     = 2 * COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic [2*COORD_BITS-1:0] t_sq;
    typedef logic [DIST_W-1:0]       t_dist;
    typedef logic [INDEX_W-1:0]      t_index;

    // action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // status codes
    localparam logic [2:0] ST_CLEARED = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_FOUND   = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_node;

    typedef struct packed {
        logic [1:0] action;
        t_coord     point_row;
        t_coord     point_col;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        t_coord     node_row;
        t_coord     node_col;
        t_index     node_index;
        t_dist      distance_sq;
    } t_out_word;

endpackage

// ----- rtl/core/nns_ram.sv -----
`timescale 1ns / 1ps

module nns_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/nns_dist.sv -----
`timescale 1ns / 1ps

// Shared squared-distance unit: |dr|,|dc| -> squares -> sum (sum is combinational
// at the output and feeds the best-so-far compare).
module nns_dist import nns_pkg::*; #(
    parameter int IDX_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [IDX_BITS-1:0] i_idx,
    input  t_node               i_node,
    input  t_coord              i_q_row,
    input  t_coord              i_q_col,
    output logic                o_valid,
    output logic                o_busy,
    output logic [IDX_BITS-1:0] o_idx,
    output t_node               o_node,
    output t_dist               o_dist
);

    logic                r_v1, r_v2;
    logic [IDX_BITS-1:0] r_idx1, r_idx2;
    t_node               r_node1, r_node2;
    t_coord              r_dr, r_dc;
    t_sq                 r_sqr, r_sqc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1  <= i_idx;
        r_node1 <= i_node;
        r_dr    <= (i_node.row >= i_q_row) ? i_node.row - i_q_row : i_q_row - i_node.row;
        r_dc    <= (i_node.col >= i_q_col) ? i_node.col - i_q_col : i_q_col - i_node.col;
        r_idx2  <= r_idx1;
        r_node2 <= r_node1;
        r_sqr   <= t_sq'(r_dr) * t_sq'(r_dr);
        r_sqc   <= t_sq'(r_dc) * t_sq'(r_dc);
    end

    assign o_valid = r_v2;
    assign o_busy  = r_v1;
    assign o_idx   = r_idx2;
    assign o_node  = r_node2;
    assign o_dist  = t_dist'(r_sqr) + t_dist'(r_sqc);

endmodule

// ----- rtl/core/nearest_node_search.sv -----
`timescale 1ns / 1ps

// Nearest-node search over a table of up to MAX_NODES 2-D grid points.
// Each input word carries an action: clear empties the table, add appends a
// point (or reports a full table), query scans every stored point and returns
// the closest one by squared Euclidean distance, earliest point on a tie,
// along with its index and the distance; a query on an empty table reports
// empty. Action code 3 is consumed and produces no output word. Every other
// input word yields exactly one output word, held until taken. Clear and add
// are answered from the idle state. A query occupies the block while it scans:
// the point table has a single read port, so the scan feeds one point per cycle
// through the shared distance unit (read, abs-diff, square, sum-and-compare),
// then drains that pipeline. The block is not ready while a query runs; it
// takes a new word as soon as it is idle and its output register is empty or
// being emptied.
module nearest_node_search import nns_pkg::*; #(
    parameter int MAX_NODES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_cnt;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    t_cnt      r_count, n_count;
    t_cnt      r_addr, n_addr;
    t_coord    r_q_row, r_q_col;
    logic      r_rd_valid;
    t_addr     r_rd_idx;
    logic      r_found, n_found;
    t_dist     r_best_d, n_best_d;
    t_addr     r_best_idx, n_best_idx;
    t_node     r_best_node, n_best_node;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;

    logic      in_acc;
    logic      out_free;
    logic      issue;
    logic      wr_en;
    t_node     wr_node;
    t_node     rd_node;
    logic      d_valid, d_busy;
    t_addr     d_idx;
    t_node     d_node;
    t_dist     d_dist;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign issue      = (r_state == S_SCAN);

    // an add to a non-full table writes the slot at the fill count
    assign wr_en   = in_acc && (i_in_word.action == ACT_ADD) && (r_count != t_cnt'(MAX_NODES));
    assign wr_node = '{row: i_in_word.point_row, col: i_in_word.point_col};

    nns_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_node),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_node)
    );

    nns_dist #(
        .IDX_BITS (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_node  (rd_node),
        .i_q_row (r_q_row),
        .i_q_col (r_q_col),
        .o_valid (d_valid),
        .o_busy  (d_busy),
        .o_idx   (d_idx),
        .o_node  (d_node),
        .o_dist  (d_dist)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_found     = r_found;
        n_best_d    = r_best_d;
        n_best_idx  = r_best_idx;
        n_best_node = r_best_node;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;

        // best-so-far; strict less-than keeps the earliest point on a tie
        if (d_valid && (!r_found || (d_dist < r_best_d))) begin
            n_found     = 1'b1;
            n_best_d    = d_dist;
            n_best_idx  = d_idx;
            n_best_node = d_node;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.action)
                        ACT_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                            n_out_word  = '{status: ST_CLEARED, default: '0};
                        end
                        ACT_ADD: begin
                            n_out_valid = 1'b1;
                            if (wr_en) begin
                                n_count    = t_cnt'(r_count + 1'b1);
                                n_out_word = '{status:      ST_ADDED,
                                               node_row:    i_in_word.point_row,
                                               node_col:    i_in_word.point_col,
                                               node_index:  t_index'(r_count[AW-1:0]),
                                               distance_sq: '0};
                            end else begin
                                n_out_word = '{status: ST_FULL, default: '0};
                            end
                        end
                        ACT_QUERY: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out_word  = '{status: ST_EMPTY, default: '0};
                            end else begin
                                n_addr  = '0;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: consumed, no output word
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_addr = t_cnt'(r_addr + 1'b1);
                if (t_cnt'(r_addr + 1'b1) == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !d_busy && !d_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{status:      ST_FOUND,
                                    node_row:    r_best_node.row,
                                    node_col:    r_best_node.col,
                                    node_index:  t_index'(r_best_idx),
                                    distance_sq: r_best_d};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_rd_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_rd_valid  <= issue;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q_row <= i_in_word.point_row;
            r_q_col <= i_in_word.point_col;
        end
        r_rd_idx    <= r_addr[AW-1:0];
        r_best_d    <= n_best_d;
        r_best_idx  <= n_best_idx;
        r_best_node <= n_best_node;
        r_out_word  <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- rtl/core/nns_checker.sv -----
`timescale 1ns / 1ps

module nns_props import nns_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status <= ST_EMPTY))
        else $error("bad status code");

    // only a found result carries a distance
    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_FOUND) |-> (o_out_word.distance_sq == '0))
        else $error("nonzero distance on non-query result");

    // a clear answers in the next cycle
    a_clear_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_word.action == ACT_CLEAR)
        |=> o_out_valid && (o_out_word.status == ST_CLEARED))
        else $error("clear not answered next cycle");

endmodule

bind nearest_node_search nns_props u_nns_props (.*);

// ----- tb/sv/nns_checker.sv -----
`timescale 1ns / 1ps

module nns_checker import nns_pkg::*; #(
    parameter int MAX_NODES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    t_node     node_table [MAX_NODES];
    int        node_total;
    t_out_word awaited_answers [$];
    t_out_word want_word;
    t_out_word got_word;
    int        fail_count;

    // Applies one input word to the shadow table; returns 1 if it yields an answer.
    function automatic bit table_answer(input t_in_word w, output t_out_word ans);
        int          dr;
        int          dc;
        int unsigned d;
        int unsigned best_d;
        int          best_i;
        ans = '0;
        case (w.action)
            ACT_CLEAR: begin
                node_total = 0;
                ans.status = ST_CLEARED;
                return 1'b1;
            end
            ACT_ADD: begin
                if (node_total >= MAX_NODES) begin
                    ans.status = ST_FULL;
                    return 1'b1;
                end
                node_table[node_total] = '{row: w.point_row, col: w.point_col};
                ans.status     = ST_ADDED;
                ans.node_row   = w.point_row;
                ans.node_col   = w.point_col;
                ans.node_index = t_index'(node_total);
                node_total++;
                return 1'b1;
            end
            ACT_QUERY: begin
                if (node_total == 0) begin
                    ans.status = ST_EMPTY;
                    return 1'b1;
                end
                // strict compare keeps the earliest node on a tie
                best_d = 32'hFFFF_FFFF;
                best_i = 0;
                for (int i = 0; i < node_total; i++) begin
                    dr = int'(node_table[i].row) - int'(w.point_row);
                    dc = int'(node_table[i].col) - int'(w.point_col);
                    d  = int'(dr * dr + dc * dc);
                    if (d < best_d) begin
                        best_d = d;
                        best_i = i;
                    end
                end
                ans.status      = ST_FOUND;
                ans.node_row    = node_table[best_i].row;
                ans.node_col    = node_table[best_i].col;
                ans.node_index  = t_index'(best_i);
                ans.distance_sq = t_dist'(best_d);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    initial begin
        node_total = 0;
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_total = 0;
            awaited_answers.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (table_answer(i_in_word, want_word))
                    awaited_answers = {awaited_answers, want_word};
            end
            if (i_out_valid && i_out_ready) begin
                got_word = i_out_word;
                if (awaited_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected word: st=%0d row=%0d col=%0d idx=%0d dsq=%0d",
                                 $time, got_word.status, got_word.node_row,
                                 got_word.node_col, got_word.node_index,
                                 got_word.distance_sq);
                end else begin
                    want_word = awaited_answers.pop_front();
                    if (got_word.status      !== want_word.status   ||
                        got_word.node_row    !== want_word.node_row ||
                        got_word.node_col    !== want_word.node_col ||
                        got_word.node_index  !== want_word.node_index ||
                        got_word.distance_sq !== want_word.distance_sq) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("[%0t] mismatch exp: st=%0d row=%0d col=%0d idx=%0d dsq=%0d",
                                     $time, want_word.status, want_word.node_row,
                                     want_word.node_col, want_word.node_index,
                                     want_word.distance_sq);
                            $display("[%0t]          got: st=%0d row=%0d col=%0d idx=%0d dsq=%0d",
                                     $time, got_word.status, got_word.node_row,
                                     got_word.node_col, got_word.node_index,
                                     got_word.distance_sq);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_answers.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import nns_pkg::*;

    localparam int MAX_NODES    = 4096;
    localparam int RANDOM_WORDS = 115;
    // Worst correct run: ~140 words, each behind an idle gap, with some output
    // stalls and a scan per query. The limit leaves a wide margin.
    localparam int CYCLE_LIMIT  = 500_000;
    // 3 is not a valid action: the block swallows it without an answer
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    int fail_count;
    int pending;
    int cycle_count;
    int stall_left   = 0;
    bit source_burst = 1'b0;  // sender runs back to back
    bit sink_burst   = 1'b0;  // receiver starts no new stalls

    always #5 i_clk = ~i_clk;

    nearest_node_search #(
        .MAX_NODES (MAX_NODES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    nns_checker #(
        .MAX_NODES (MAX_NODES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 3);
    endfunction

    // Coordinates: extremes, full range, and a tight cluster that breeds ties.
    function automatic t_coord pick_coord();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_coord'($urandom);
            default: return t_coord'(500 + $urandom_range(0, 3));
        endcase
    endfunction

    // Output side: random stalls unless in a burst stretch.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_burst || $urandom_range(0, 3) != 0) begin
            out_ready <= 1'b1;
        end else begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // Presents one word and returns at the edge where it is taken. With no gap
    // the next word follows in the acceptance cycle, valid staying high.
    task automatic send_word(input logic [1:0] act, input t_coord row, input t_coord col);
        t_in_word w;
        int       gap;
        w.action    = act;
        w.point_row = row;
        w.point_col = col;
        gap = source_burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Sender holds off until every awaited answer is back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_word(ACT_CLEAR, pick_coord(), pick_coord());
        else if (pick < 50)
            send_word(ACT_ADD, pick_coord(), pick_coord());
        else if (pick < 95)
            send_word(ACT_QUERY, pick_coord(), pick_coord());
        else
            send_word(ACT_UNUSED, pick_coord(), pick_coord());
    endtask

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty table, extremes, ties, unused code, clear ---
        send_word(ACT_QUERY,  10'd0,    10'd0);     // query before any add
        send_word(ACT_UNUSED, 10'd1023, 10'd1023);  // swallowed, no answer
        send_word(ACT_ADD,    10'd0,    10'd0);
        send_word(ACT_ADD,    10'd1023, 10'd1023);
        send_word(ACT_ADD,    10'd0,    10'd1023);
        send_word(ACT_ADD,    10'd1023, 10'd0);
        send_word(ACT_ADD,    10'd512,  10'd512);
        send_word(ACT_ADD,    10'd512,  10'd512);   // duplicate: index 4 must win
        send_word(ACT_ADD,    10'd100,  10'd100);
        send_word(ACT_ADD,    10'd102,  10'd102);
        send_word(ACT_QUERY,  10'd1023, 10'd1023);  // exact hit
        send_word(ACT_QUERY,  10'd0,    10'd0);
        send_word(ACT_QUERY,  10'd512,  10'd512);
        send_word(ACT_QUERY,  10'd101,  10'd101);   // equidistant pair, earlier kept
        send_word(ACT_QUERY,  10'd1023, 10'd511);
        send_word(ACT_UNUSED, 10'd0,    10'd0);
        send_word(ACT_CLEAR,  10'd0,    10'd0);
        send_word(ACT_QUERY,  10'd5,    10'd5);     // empty after clear
        send_word(ACT_ADD,    10'd0,    10'd0);
        send_word(ACT_QUERY,  10'd1023, 10'd1023);  // largest possible distance
        send_word(ACT_CLEAR,  10'd1023, 10'd1023);  // coords ignored on clear
        drain();

        // --- random: frequent clears keep the table small and scans short ---
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 35 == 0) begin
                source_burst <= ($urandom_range(0, 2) == 0);
                sink_burst   <= ($urandom_range(0, 2) == 0);
            end
            send_random_word();
            if (n == RANDOM_WORDS / 2)
                drain();
        end
        drain();

        // --- short tail: empty again, index restarts at zero ---
        source_burst <= 1'b0;
        sink_burst   <= 1'b0;
        send_word(ACT_CLEAR, 10'd0, 10'd0);
        send_word(ACT_QUERY, 10'd1, 10'd1);        // empty again
        send_word(ACT_ADD,   10'd3, 10'd4);        // index restarts at zero
        send_word(ACT_QUERY, 10'd1023, 10'd0);
        drain();

        // catch any stray late word
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
